FILE: rtl/core/indexed_sprite_alpha_blit_defines.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the sprite blitter RTL.
// ============================================================================
`ifndef INDEXED_SPRITE_ALPHA_BLIT_DEFINES_SVH
`define INDEXED_SPRITE_ALPHA_BLIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ISAB_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ISAB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/isab_pkg.sv
// ============================================================================
// isab_pkg
// Types and constants shared by the sprite blitter modules.
// ============================================================================
package isab_pkg;

    localparam int DEF_MAX_DIM   = 4096;
    localparam int DEF_ADDR_BITS = 24;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] REG_ALPHA_MODE    = 3'd0;
    localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_FRAME_STRIDE  = 3'd3;
    localparam logic [2:0] REG_DEST_START    = 3'd4;

    localparam logic [4:0] OPAQUE_BITS = 5'd9;
    localparam logic [4:0] BYTE_BITS   = 5'd8;
    localparam logic [2:0] LAST_SLOT   = 3'd7;
    localparam logic [7:0] INDEX_MASK  = 8'hFF;

    typedef struct packed {
        logic        alpha_mode;
        logic [12:0] sprite_width;
        logic [12:0] sprite_height;
        logic [12:0] frame_stride;
        logic [23:0] dest_start;
    } cfg_t;

    typedef struct packed {
        logic [7:0] index;
        logic       we;
        logic       done;
        logic       last;
        logic       first;
        logic       eol;
    } token_t;

endpackage

FILE: rtl/core/isab_front.sv
// ============================================================================
// isab_front
// Byte intake and bit-stream parser; emits one pixel token per cycle while
// the queue has room and bits suffice, and tracks the sprite row and column.
// ============================================================================
`include "indexed_sprite_alpha_blit_defines.svh"

module isab_front
    import isab_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] bitmap_byte,
    output logic       tok_valid,
    input  logic       tok_ready,
    output token_t     tok
);

    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int CW       = DIM_BITS + 1;

    logic [15:0]         buf_reg, buf_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [2:0]          n_reg, n_next;
    logic                act_reg, act_next;
    logic [DIM_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;

    logic [CW-1:0] w_eff, h_eff, col_inc, row_inc;
    logic          eol, done, can, emit, last, accept, zero;
    logic [7:0]    t_idx;
    logic          t_we;
    logic [15:0]   pb, pb_d, post_buf;
    logic [4:0]    pc, pc_d, post_cnt;

    always_comb
    begin
        if (cfg.sprite_width == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(cfg.sprite_width) > MAX_DIM)
        begin
            w_eff = CW'(MAX_DIM);
        end
        else
        begin
            w_eff = CW'(cfg.sprite_width);
        end
        if (cfg.sprite_height == '0)
        begin
            h_eff = CW'(1);
        end
        else if (32'(cfg.sprite_height) > MAX_DIM)
        begin
            h_eff = CW'(MAX_DIM);
        end
        else
        begin
            h_eff = CW'(cfg.sprite_height);
        end
    end

    assign col_inc = {1'b0, col_reg} + CW'(1);
    assign row_inc = {1'b0, row_reg} + CW'(1);
    assign eol     = col_inc >= w_eff;
    assign done    = eol && (row_inc >= h_eff);
    assign zero    = ~buf_reg[0];

    always_comb
    begin
        if (!cfg.alpha_mode)
        begin
            can   = act_reg;
            t_idx = buf_reg[7:0] & INDEX_MASK;
            t_we  = 1'b1;
            pb    = '0;
            pc    = '0;
        end
        else
        begin
            can = act_reg && (cnt_reg != '0) && (zero || (cnt_reg >= OPAQUE_BITS));
            if (zero)
            begin
                t_idx = '0;
                t_we  = 1'b0;
                pb    = buf_reg >> 1;
                pc    = cnt_reg - 5'd1;
            end
            else
            begin
                t_idx = buf_reg[8:1];
                t_we  = 1'b1;
                pb    = buf_reg >> OPAQUE_BITS;
                pc    = cnt_reg - OPAQUE_BITS;
            end
        end
    end

    assign emit = can && tok_ready;
    assign pb_d = done ? '0 : pb;
    assign pc_d = done ? '0 : pc;
    assign last = !cfg.alpha_mode || done || (n_reg == LAST_SLOT) || (pc_d == '0)
                  || (pb_d[0] && (pc_d < OPAQUE_BITS));

    assign post_buf = emit ? pb_d : buf_reg;
    assign post_cnt = emit ? pc_d : cnt_reg;

    assign in_ready = !act_reg || !can || (emit && last);
    assign accept   = in_valid && in_ready;

    assign tok_valid = can;
    always_comb
    begin
        tok.index = t_idx;
        tok.we    = t_we;
        tok.done  = done;
        tok.last  = last;
        tok.first = (col_reg == '0) && (row_reg == '0);
        tok.eol   = eol;
    end

    always_comb
    begin
        buf_next = post_buf;
        cnt_next = post_cnt;
        n_next   = n_reg;
        act_next = act_reg;
        if (accept)
        begin
            if (cfg.alpha_mode)
            begin
                buf_next = post_buf | (16'(bitmap_byte) << post_cnt[3:0]);
                cnt_next = post_cnt + BYTE_BITS;
            end
            else
            begin
                buf_next = {8'h00, bitmap_byte};
                cnt_next = '0;
            end
            n_next   = '0;
            act_next = 1'b1;
        end
        else if (emit)
        begin
            n_next   = n_reg + 3'd1;
            act_next = !last;
        end
        else if (act_reg && !can)
        begin
            act_next = 1'b0;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (emit)
        begin
            if (eol)
            begin
                col_next = '0;
                row_next = done ? '0 : row_inc[DIM_BITS-1:0];
            end
            else
            begin
                col_next = col_inc[DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= '0;
            n_reg   <= '0;
            act_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            n_reg   <= n_next;
            act_reg <= act_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `ISAB_ASSERT_NEXT(a_byte_mode_ready, accept && !cfg.alpha_mode, act_reg && can, "byte mode load not emitting")
    `ISAB_ASSERT_NOW(a_done_at_row_end, tok_valid && tok.done, tok.eol && !(tok.first && !eol), "sprite end off row end")

endmodule

FILE: rtl/core/isab_queue.sv
// ============================================================================
// isab_queue
// Short token queue between the parser and the address unit.
// ============================================================================
`include "indexed_sprite_alpha_blit_defines.svh"

module isab_queue
    import isab_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  token_t push_tok,
    output logic   pop_valid,
    input  logic   pop_ready,
    output token_t pop_tok
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    token_t              mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push, pop;

    assign push_ready = count_reg != CNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = mem[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + PTR_BITS'(1) : wr_reg;
        rd_next    = pop ? rd_reg + PTR_BITS'(1) : rd_reg;
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    `ISAB_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_BITS'(QUEUE_DEPTH), "queue overfilled")
    `ISAB_ASSERT_NOW(a_ptr_gap, count_reg == '0, wr_reg == rd_reg, "queue pointers out of step")

endmodule

FILE: rtl/core/isab_back.sv
// ============================================================================
// isab_back
// Address unit: turns pixel tokens into framebuffer addresses and holds the
// result register of the output channel.
// ============================================================================
`include "indexed_sprite_alpha_blit_defines.svh"

module isab_back
    import isab_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 tok_valid,
    output logic                 tok_ready,
    input  token_t               tok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_BITS-1:0] pixel_address,
    output logic [7:0]           palette_index,
    output logic                 write_enable,
    output logic                 sprite_done,
    output logic                 last_of_run
);

    logic                 ov_reg, ov_next;
    logic [ADDR_BITS-1:0] addr_reg, cur_reg, rs_reg;
    logic [ADDR_BITS-1:0] dest_eff, addr, rs_eff, row_next_addr;
    logic [7:0]           idx_reg;
    logic                 we_reg, done_reg, last_reg;
    logic                 pop;

    assign dest_eff      = ADDR_BITS'(cfg.dest_start);
    assign tok_ready     = !ov_reg || out_ready;
    assign pop           = tok_valid && tok_ready;
    assign addr          = tok.first ? dest_eff : cur_reg;
    assign rs_eff        = tok.first ? dest_eff : rs_reg;
    assign row_next_addr = rs_eff + ADDR_BITS'(cfg.frame_stride);

    always_comb
    begin
        ov_next = ov_reg;
        if (pop)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= addr;
            idx_reg  <= tok.index;
            we_reg   <= tok.we;
            done_reg <= tok.done;
            last_reg <= tok.last;
            if (tok.eol)
            begin
                cur_reg <= row_next_addr;
                rs_reg  <= row_next_addr;
            end
            else
            begin
                cur_reg <= addr + ADDR_BITS'(1);
                rs_reg  <= rs_eff;
            end
        end
    end

    assign out_valid     = ov_reg;
    assign pixel_address = addr_reg;
    assign palette_index = idx_reg;
    assign write_enable  = we_reg;
    assign sprite_done   = done_reg;
    assign last_of_run   = last_reg;

    `ISAB_ASSERT_NEXT(a_first_addr, pop && tok.first, pixel_address == $past(dest_eff), "first pixel not at start")
    `ISAB_ASSERT_NOW(a_transparent_zero, out_valid && !write_enable, palette_index == '0, "transparent pixel with index")

endmodule

FILE: rtl/core/indexed_sprite_alpha_blit.sv
// ============================================================================
// indexed_sprite_alpha_blit
// Indexed sprite blitter with optional 1-bit alpha bit stream.
// ============================================================================
// Input channel (in_valid/in_ready, bitmap_byte): one sprite bitmap byte per
// transaction. Output channel (out_valid/out_ready): one pixel per
// transaction, row-major, with its framebuffer address, palette index, write
// enable (0 = transparent), sprite_done on the final pixel and last_of_run
// on the last pixel a byte produces.
// Configuration: write cfg_data to register cfg_index while cfg_write_en is
// high, only while the block is idle.
// The first pixel of a byte passes the bit buffer, the token queue and the
// output register before out_valid rises.
// Throughput: one pixel per cycle while the receiver keeps up and the bits
// suffice, set by the parser emitting one pixel per cycle. In byte mode one
// byte per cycle; in alpha mode a byte waits until the one before is parsed.
// A four-entry token queue sits between the parser and the address unit, and
// the output register lets the parser keep going while a result waits.
// When the receiver stalls, the queue fills and in_ready drops.
// Reset clears the bit buffer, the position counters, the queue and the
// registers to their defaults; the next byte starts a new sprite.
// ============================================================================
module indexed_sprite_alpha_blit
    import isab_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           bitmap_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_BITS-1:0] pixel_address,
    output logic [7:0]           palette_index,
    output logic                 write_enable,
    output logic                 sprite_done,
    output logic                 last_of_run
);

    cfg_t   cfg_reg, cfg_next;
    logic   f_valid, f_ready, b_valid, b_ready;
    token_t f_tok, b_tok;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ALPHA_MODE:    cfg_next.alpha_mode    = cfg_data[0];
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_data[12:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_data[12:0];
                REG_FRAME_STRIDE:  cfg_next.frame_stride  = cfg_data[12:0];
                REG_DEST_START:    cfg_next.dest_start    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_mode    <= 1'b0;
            cfg_reg.sprite_width  <= 13'd1;
            cfg_reg.sprite_height <= 13'd1;
            cfg_reg.frame_stride  <= 13'd1;
            cfg_reg.dest_start    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    isab_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .bitmap_byte (bitmap_byte),
        .tok_valid   (f_valid),
        .tok_ready   (f_ready),
        .tok         (f_tok)
    );

    isab_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_tok   (f_tok),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_tok    (b_tok)
    );

    isab_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .tok_valid     (b_valid),
        .tok_ready     (b_ready),
        .tok           (b_tok),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .palette_index (palette_index),
        .write_enable  (write_enable),
        .sprite_done   (sprite_done),
        .last_of_run   (last_of_run)
    );

endmodule
